// ===== design/u16u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the queue entry and status types, the size constants and the byte encoder.
// It depends on nothing else.
package u16u8_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] PAIR_BIAS = 21'h02400;

	typedef enum logic [1:0] {
		LEN_ONE   = 2'd0,
		LEN_TWO   = 2'd1,
		LEN_THREE = 2'd2,
		LEN_FOUR  = 2'd3
	} len_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		len_t            len;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam logic [7:0] LEAD4_TAG = 8'b1111_0000;
	localparam logic [7:0] LEAD3_TAG = 8'b1110_0000;
	localparam logic [7:0] LEAD2_TAG = 8'b1100_0000;
	localparam logic [7:0] CONT_TAG  = 8'b1000_0000;

	function automatic logic [7:0] encode_byte(input logic [CP_W-1:0] cp, input len_t len,
			input logic [1:0] idx);
		logic [7:0] b;
		b = CONT_TAG | {2'b00, cp[5:0]};
		case (len)
			LEN_ONE: begin
				b = cp[7:0];
			end
			LEN_TWO: begin
				if (idx == 2'd0) begin
					b = LEAD2_TAG | {3'b000, cp[10:6]};
				end
			end
			LEN_THREE: begin
				if (idx == 2'd0) begin
					b = LEAD3_TAG | {4'b0000, cp[15:12]};
				end else if (idx == 2'd1) begin
					b = CONT_TAG | {2'b00, cp[11:6]};
				end
			end
			LEN_FOUR: begin
				if (idx == 2'd0) begin
					b = LEAD4_TAG | {5'b00000, cp[20:18]};
				end else if (idx == 2'd1) begin
					b = CONT_TAG | {2'b00, cp[17:12]};
				end else if (idx == 2'd2) begin
					b = CONT_TAG | {2'b00, cp[11:6]};
				end
			end
			default: begin
				b = CONT_TAG | {2'b00, cp[5:0]};
			end
		endcase
		return b;
	endfunction

endpackage

// ===== design/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder, top level.
// Instantiates u16u8_front, u16u8_fifo and u16u8_back; uses u16u8_pkg.
// The block takes one UTF-16 code unit per request and returns its UTF-8 bytes, one byte
// per request on the output, with run_last marking the final byte of each unit. A unit
// is accepted in every cycle while the job queue of QUEUE_DEPTH entries has room; the
// output delivers one byte per cycle while out_stall is low, one to three bytes per unit by
// its code point and four for a surrogate pair, set by the back-end byte serializer. The
// first byte of a unit passes through the job queue and then the registered output stage.
// A held lead produces no output, and a lead that ends a string is dropped.
module utf16_to_utf8_transcoder #(
	parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        string_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	u16u8_pkg::q_status_t q_status;
	u16u8_pkg::job_t      push_job;
	u16u8_pkg::job_t      head_job;
	logic                 push;
	logic                 pop;

	u16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.string_last (string_last),
		.q_status    (q_status),
		.push        (push),
		.push_job    (push_job)
	);

	u16u8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_status (q_status)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

// ===== design/u16u8_front.sv =====
// Front end of the transcoder: accepts code units, pairs surrogates, classifies lengths.
// Pushes one code point and byte count per encoded unit into the queue; uses u16u8_pkg.
module u16u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          code_unit,
	input  logic                 string_last,
	input  u16u8_pkg::q_status_t q_status,
	output logic                 push,
	output u16u8_pkg::job_t      push_job
);

	logic        lead_pending_q;
	logic [10:0] lead_offset_q;
	logic        accept;
	logic        is_surr;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign is_surr  = code_unit[15:11] == 5'b11011;

	always_comb begin
		push_job.cp  = {5'b00000, code_unit};
		push_job.len = u16u8_pkg::LEN_ONE;
		push         = accept;
		if (lead_pending_q) begin
			push_job.cp  = {lead_offset_q, 10'b0} + {5'b00000, code_unit} + u16u8_pkg::PAIR_BIAS;
			push_job.len = u16u8_pkg::LEN_FOUR;
		end else if (is_surr) begin
			push = 1'b0;
		end else if (code_unit[15:11] != 5'b00000) begin
			push_job.len = u16u8_pkg::LEN_THREE;
		end else if (code_unit[10:7] != 4'b0000) begin
			push_job.len = u16u8_pkg::LEN_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_offset_q  <= '0;
		end else if (accept) begin
			if (lead_pending_q) begin
				lead_pending_q <= 1'b0;
			end else if (is_surr && !string_last) begin
				lead_pending_q <= 1'b1;
				lead_offset_q  <= code_unit[10:0];
			end
		end
	end

endmodule

// ===== design/u16u8_fifo.sv =====
// Short queue of encode jobs between the front and back ends of the transcoder.
// Register array with read and write pointers; uses u16u8_pkg for the entry type.
module u16u8_fifo #(
	parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u16u8_pkg::job_t      push_job,
	input  logic                 pop,
	output u16u8_pkg::job_t      head_job,
	output u16u8_pkg::q_status_t q_status
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	u16u8_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_job       = mem_q[rd_ptr_q];
	assign q_status.full  = count_q == CW'(DEPTH);
	assign q_status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !pop)
		else $error("pop from an empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not follow a push");
`endif

endmodule

// ===== design/u16u8_back.sv =====
// Back end of the transcoder: serializes each queued job into UTF-8 bytes.
// Drives the registered output channel; uses u16u8_pkg for the byte encoder.
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::job_t      head_job,
	input  u16u8_pkg::q_status_t q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 run_last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;
	logic       last_v;

	assign load   = !out_valid_q || !out_stall;
	assign take   = load && !q_status.empty;
	assign last_v = idx_q == head_job.len;
	assign pop    = take && last_v;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !q_status.empty;
			end
			if (take) begin
				idx_q <= last_v ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= u16u8_pkg::encode_byte(head_job.cp, head_job.len, idx_q);
			run_last_q <= last_v;
		end
	end

endmodule
